>>> hw/rtl/f2h_pkg.sv
// Package: shared types and constants for the single-to-half converter.
`timescale 1ns / 1ps
package f2h_pkg;
  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [15:0] HALF_QNAN = 16'h7E00;

  // Decode stage result handed to the shift stage.
  typedef struct packed {
    logic        sign;
    logic        special;   // magnitude fixed: inf or nan
    logic [14:0] fixed_mag;
    logic        normal;
    logic [14:0] q_norm;    // exponent and top mantissa bits
    logic [12:0] rem_norm;
    logic [23:0] sig;       // significand for the subnormal path
    logic [4:0]  shamt;     // 14..25 on the subnormal path
    logic        last;
  } f2h_dec_t;

  // Shift stage result handed to the rounding stage.
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [14:0] fixed_mag;
    logic [14:0] q;
    logic        rnd;       // bit just below q
    logic        sticky;    // any bit below rnd
    logic        last;
  } f2h_sh_t;
endpackage

>>> hw/rtl/fp32_to_fp16_convert_unit.sv
// Top level: pipelined binary32 to binary16 converter, round to nearest even.
//
//  channel | dir | tdata                   | tlast
//  in_     | in  | [31:0] single_bits      | last_in
//  out_    | out | [15:0] half_bits        | last_out
//
// Three register stages (decode, shift, round); one transaction per cycle
// sustained while out_tready stays high.
// Reset clears stage valid bits only; payload registers are not reset.
// A stall holds each full stage with no empty stage after it; a stage advances when the one after it
// is empty or moving, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module fp32_to_fp16_convert_unit import f2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] single_bits
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] half_bits
  output logic        out_tlast   // last_out
);
  f2h_dec_t dec_w, dec_r;
  f2h_sh_t  sh_w, sh_r;
  logic [15:0] half_w, half_r;
  logic last_r;
  logic v1_r, v2_r, v3_r;
  logic go1, go2, go3;

  f2h_decode u_dec (.single_bits(in_tdata), .last_in(in_tlast), .dec(dec_w));
  f2h_shift  u_sh  (.dec(dec_r), .sh(sh_w));
  f2h_round  u_rnd (.sh(sh_r), .half_bits(half_w));

  // Advance a stage when its downstream slot frees up.
  assign go3 = !v3_r || out_tready;
  assign go2 = !v2_r || go3;
  assign go1 = !v1_r || go2;
  assign in_tready = go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (go1) v1_r <= in_tvalid;
      if (go2) v2_r <= v1_r;
      if (go3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) dec_r <= dec_w;
    if (go2) sh_r <= sh_w;
    if (go3) begin
      half_r <= half_w;
      last_r <= sh_r.last;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = half_r;
  assign out_tlast  = last_r;
endmodule

>>> hw/rtl/f2h_decode.sv
// Decode stage: split fields and classify the binary32 input.
`timescale 1ns / 1ps
module f2h_decode import f2h_pkg::*; (
  input  logic [31:0] single_bits,
  input  logic        last_in,
  output f2h_dec_t    dec
);
  logic [7:0] e;
  logic [22:0] m;
  always_comb begin
    e = single_bits[30:23];
    m = single_bits[22:0];
    dec = '0;
    dec.sign = single_bits[31];
    dec.last = last_in;
    dec.sig = (e != 8'd0) ? {1'b1, m} : {1'b0, m};
    dec.shamt = (e >= 8'd101) ? 5'(8'd126 - e) : 5'd25;
    dec.q_norm = {5'(e - 8'd112), m[22:13]};
    dec.rem_norm = m[12:0];
    if (e == 8'hFF) begin
      dec.special = 1'b1;
      dec.fixed_mag = (m != 23'd0) ? HALF_QNAN[14:0] : HALF_INF[14:0];
    end else if (e >= 8'd143) begin
      dec.special = 1'b1;
      dec.fixed_mag = HALF_INF[14:0];
    end else begin
      dec.normal = (e >= 8'd113);
    end
  end
endmodule

>>> hw/rtl/f2h_shift.sv
// Shift stage: align significand and form round and sticky bits.
`timescale 1ns / 1ps
module f2h_shift import f2h_pkg::*; (
  input  f2h_dec_t dec,
  output f2h_sh_t  sh
);
  logic [49:0] wide;
  always_comb begin
    wide = {dec.sig, 26'd0} >> dec.shamt;
    sh.sign = dec.sign;
    sh.special = dec.special;
    sh.fixed_mag = dec.fixed_mag;
    sh.last = dec.last;
    if (dec.normal) begin
      sh.q = dec.q_norm;
      sh.rnd = dec.rem_norm[12];
      sh.sticky = |dec.rem_norm[11:0];
    end else begin
      sh.q = {5'd0, wide[35:26]};
      sh.rnd = wide[25];
      sh.sticky = |wide[24:0];
    end
  end
endmodule

>>> hw/rtl/f2h_round.sv
// Round stage: nearest-even increment, overflow clamp, special select.
`timescale 1ns / 1ps
module f2h_round import f2h_pkg::*; (
  input  f2h_sh_t     sh,
  output logic [15:0] half_bits
);
  logic [14:0] mag;
  always_comb begin
    mag = sh.q + 15'(sh.rnd & (sh.sticky | sh.q[0]));
    if (mag > HALF_INF[14:0]) mag = HALF_INF[14:0];
    if (sh.special) mag = sh.fixed_mag;
    half_bits = {sh.sign, mag};
  end
endmodule

>>> verif/f2h_checker.sv
// Checker: watches both channels, predicts each half result and compares.
`timescale 1ns / 1ps
module f2h_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [15:0] half;
    logic        last;
  } half_item_t;

  half_item_t half_queue[$];
  int         report_count;

  function automatic logic [31:0] rne(logic [31:0] q, logic [31:0] rem, int s);
    logic [31:0] halfway;
    halfway = 32'd1 << (s - 1);
    if (rem > halfway || (rem == halfway && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic logic [15:0] single_to_half(logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] m;
    logic [31:0] mag;
    logic [31:0] sig;
    int          s;
    e = x[30:23];
    m = x[22:0];
    if (e == 8'hFF) begin
      mag = (m != 0) ? 32'h7E00 : 32'h7C00;
    end else if (e >= 143) begin
      mag = 32'h7C00;
    end else if (e >= 113) begin
      mag = rne(((32'(e) - 32'd112) << 10) | 32'(m >> 13), 32'(m & 23'h1FFF), 13);
      if (mag > 32'h7C00) mag = 32'h7C00;
    end else begin
      sig = (e != 0) ? {8'd0, 1'b1, m} : {9'd0, m};
      s = (e >= 101) ? (126 - int'(e)) : 25;
      mag = rne(sig >> s, sig & ((32'd1 << s) - 32'd1), s);
    end
    return {x[31], mag[14:0]};
  endfunction

  assign pending = half_queue.size();

  always @(posedge clk) begin
    half_item_t want;
    if (!rst_n) begin
      fail_count   <= 0;
      report_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        half_queue.push_back({single_to_half(in_tdata), in_tlast});
      if (out_tvalid && out_tready) begin
        if (half_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (report_count < 10) $display("unexpected result %h", out_tdata);
          report_count <= report_count + 1;
        end else begin
          want = half_queue.pop_front();
          if (want.half !== out_tdata || want.last !== out_tlast) begin
            fail_count <= fail_count + 1;
            if (report_count < 10)
              $display("mismatch: expected %h/%b got %h/%b",
                       want.half, want.last, out_tdata, out_tlast);
            report_count <= report_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/fp32_to_fp16_convert_unit_tb.sv
// Testbench top: drives stimulus into the converter and gives the verdict.
`timescale 1ns / 1ps
module fp32_to_fp16_convert_unit_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          stall_pct = 0;   // receiver stall rate for the current phase

  always #5 clk = ~clk;

  fp32_to_fp16_convert_unit DUT (.*);

  f2h_checker checker_i (.*);

  // Bound the run; the slowest correct run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the receiver at the phase's rate.
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= stall_pct);

  // Hold one transaction until accepted; idle the sender at gap_pct.
  task automatic send_single(logic [31:0] bits, int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    in_tlast  <= 1'($urandom_range(1));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Pick random singles, weighted toward the exponents where rounding is interesting.
  function automatic logic [31:0] random_single();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(5))
      0: x[30:23] = 8'($urandom_range(98, 145));
      1: x[30:23] = 8'($urandom_range(110, 143));
      2: begin
        x[30:23] = 8'($urandom_range(101, 142));
        x[12:0] = ($urandom_range(1)) ? 13'h1000 : x[12:0];  // exact tie for normal exponents
      end
      3: x[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return x;
  endfunction

  localparam logic [31:0] DIRECTED [22] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFF80_0001, 32'h7FFF_FFFF, 32'h477F_E000,
    32'h477F_F000, 32'h477F_EFFF, 32'hC780_0000, 32'h3880_0000,
    32'h387F_E000, 32'h3380_0000, 32'h3300_0000, 32'h3300_0001,
    32'h33C0_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000,
    32'h3F80_1000, 32'h3F80_3000
  };

  initial begin
    int gaps [4]   = '{0, 63, 0, 22};
    int stalls [4] = '{0, 0, 63, 22};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) send_single(DIRECTED[i], 0);
    for (int ph = 0; ph < 4; ph++) begin
      stall_pct = stalls[ph];
      for (int n = 0; n < 220; n++) send_single(random_single(), gaps[ph]);
      // Pause the sender until every expected result has come back.
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
